/* rtl/spi_tx_rx_ring_buffers_core_assert.svh */
// ----------------------------------------------------------------------------
// spi_tx_rx_ring_buffers_core assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SPI_TX_RX_RING_BUFFERS_CORE_ASSERT_SVH
`define SPI_TX_RX_RING_BUFFERS_CORE_ASSERT_SVH

// same-cycle implication
`define SPI_TRB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// plain invariant
`define SPI_TRB_ASSERT_ALWAYS(label, cond, msg) \
	`SPI_TRB_ASSERT_NOW(label, 1'b1, cond, msg)

`endif

/* rtl/spi_trb_pkg.sv */
// ----------------------------------------------------------------------------
// spi_trb_pkg
// shared constants and types for the spi transmit and receive ring buffers
// ----------------------------------------------------------------------------
package spi_trb_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_SEND = 2'd0,
		OP_POP  = 2'd1,
		OP_DONE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_SEND_FULL      = 3'd1,
		ST_READ_EMPTY     = 3'd2,
		ST_RECV_OVERWRITE = 3'd3,
		ST_NOTHING_QUEUED = 3'd4
	} status_t;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		next_idx = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
	endfunction

endpackage

/* rtl/spi_trb_ram.sv */
// ----------------------------------------------------------------------------
// spi_trb_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module spi_trb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/spi_tx_rx_ring_buffers_core.sv */
// ----------------------------------------------------------------------------
// spi_tx_rx_ring_buffers_core
// send and receive byte queues around a byte-wide spi shifter
// ----------------------------------------------------------------------------
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | opcode, data, last_of_burst
// out     | out_valid | out_stall | status, read_byte, shift_load_valid,
//         |           |           | shift_load_byte, send_count, recv_count
//
// one transaction per cycle while not stalled; results leave the output register
// queue pointers and counts update at accept, ram read lands in the read stage
// reset clears pointers, counts and burst flags; ram contents are not cleared
// a stalled result waits in the output register while one more transaction
// is taken into the read stage
// ----------------------------------------------------------------------------
`include "spi_tx_rx_ring_buffers_core_assert.svh"

module spi_tx_rx_ring_buffers_core
	import spi_trb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] data,
	input  logic       last_of_burst,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic [7:0] read_byte,
	output logic       shift_load_valid,
	output logic [7:0] shift_load_byte,
	output logic [4:0] send_count,
	output logic [4:0] recv_count
);

	// queue state
	logic [IDX_W-1:0] send_head_q, send_tail_q, recv_head_q, recv_tail_q;
	logic [CNT_W-1:0] send_cnt_q, recv_cnt_q;
	logic             burst_open_q, burst_empty_q;

	logic [IDX_W-1:0] send_head_d, send_tail_d, recv_head_d, recv_tail_d;
	logic [CNT_W-1:0] send_cnt_d, recv_cnt_d;
	logic             burst_open_d, burst_empty_d;

	// ram controls
	logic             send_we, send_re, recv_we, recv_re;
	logic [IDX_W-1:0] send_raddr;
	logic [7:0]       send_rdata, recv_rdata;

	// per transaction results
	status_t          st_d;
	logic             pop_d, load_d, fwd_d;

	// read stage
	logic             valid_s1, pop_s1, load_s1, fwd_s1;
	status_t          st_s1;
	logic [7:0]       fwd_byte_s1;
	logic [CNT_W-1:0] send_cnt_s1, recv_cnt_s1;

	// output register
	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [7:0]       read_byte_q, load_byte_q;
	logic             load_valid_q;
	logic [4:0]       send_count_q, recv_count_q;

	logic accept, s1_adv;

	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		send_head_d   = send_head_q;
		send_tail_d   = send_tail_q;
		send_cnt_d    = send_cnt_q;
		recv_head_d   = recv_head_q;
		recv_tail_d   = recv_tail_q;
		recv_cnt_d    = recv_cnt_q;
		burst_open_d  = burst_open_q;
		burst_empty_d = burst_empty_q;
		send_we       = 1'b0;
		send_re       = 1'b0;
		send_raddr    = send_head_q;
		recv_we       = 1'b0;
		recv_re       = 1'b0;
		st_d          = ST_OK;
		pop_d         = 1'b0;
		load_d        = 1'b0;
		fwd_d         = 1'b0;
		unique case (op_t'(opcode))
			OP_SEND: begin
				if (!burst_open_q) begin
					burst_empty_d = (send_cnt_q == '0);
				end
				burst_open_d = 1'b1;
				if (send_cnt_q == CNT_W'(QUEUE_DEPTH)) begin
					st_d = ST_SEND_FULL;
				end else begin
					send_we     = 1'b1;
					send_tail_d = next_idx(send_tail_q);
					send_cnt_d  = send_cnt_q + CNT_W'(1);
				end
				if (last_of_burst) begin
					if (burst_empty_d && send_cnt_d != '0) begin
						load_d  = 1'b1;
						send_re = 1'b1;
						// head entry is being written by this same transaction
						fwd_d   = (send_cnt_q == '0);
					end
					burst_open_d  = 1'b0;
					burst_empty_d = 1'b0;
				end
			end
			OP_POP: begin
				if (recv_cnt_q == '0) begin
					st_d = ST_READ_EMPTY;
				end else begin
					pop_d       = 1'b1;
					recv_re     = 1'b1;
					recv_head_d = next_idx(recv_head_q);
					recv_cnt_d  = recv_cnt_q - CNT_W'(1);
				end
			end
			OP_DONE: begin
				recv_we     = 1'b1;
				recv_tail_d = next_idx(recv_tail_q);
				if (recv_cnt_q == CNT_W'(QUEUE_DEPTH)) begin
					recv_head_d = next_idx(recv_head_q);
					st_d        = ST_RECV_OVERWRITE;
				end else begin
					recv_cnt_d = recv_cnt_q + CNT_W'(1);
				end
				if (send_cnt_q == '0) begin
					st_d = ST_NOTHING_QUEUED;
				end else begin
					send_head_d = next_idx(send_head_q);
					send_cnt_d  = send_cnt_q - CNT_W'(1);
					send_raddr  = send_head_d;
					if (send_cnt_d != '0) begin
						load_d  = 1'b1;
						send_re = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	spi_trb_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_send_ram (
		.clk   (clk),
		.we    (accept && send_we),
		.waddr (send_tail_q),
		.wdata (data),
		.re    (accept && send_re),
		.raddr (send_raddr),
		.rdata (send_rdata)
	);

	spi_trb_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_recv_ram (
		.clk   (clk),
		.we    (accept && recv_we),
		.waddr (recv_tail_q),
		.wdata (data),
		.re    (accept && recv_re),
		.raddr (recv_head_q),
		.rdata (recv_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_head_q   <= '0;
			send_tail_q   <= '0;
			send_cnt_q    <= '0;
			recv_head_q   <= '0;
			recv_tail_q   <= '0;
			recv_cnt_q    <= '0;
			burst_open_q  <= 1'b0;
			burst_empty_q <= 1'b0;
		end else if (accept) begin
			send_head_q   <= send_head_d;
			send_tail_q   <= send_tail_d;
			send_cnt_q    <= send_cnt_d;
			recv_head_q   <= recv_head_d;
			recv_tail_q   <= recv_tail_d;
			recv_cnt_q    <= recv_cnt_d;
			burst_open_q  <= burst_open_d;
			burst_empty_q <= burst_empty_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1       <= st_d;
			pop_s1      <= pop_d;
			load_s1     <= load_d;
			fwd_s1      <= fwd_d;
			fwd_byte_s1 <= data;
			send_cnt_s1 <= send_cnt_d;
			recv_cnt_s1 <= recv_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_q     <= st_s1;
			read_byte_q  <= pop_s1 ? recv_rdata : 8'd0;
			load_valid_q <= load_s1;
			load_byte_q  <= load_s1 ? (fwd_s1 ? fwd_byte_s1 : send_rdata) : 8'd0;
			send_count_q <= 5'(send_cnt_s1);
			recv_count_q <= 5'(recv_cnt_s1);
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign read_byte        = read_byte_q;
	assign shift_load_valid = load_valid_q;
	assign shift_load_byte  = load_byte_q;
	assign send_count       = send_count_q;
	assign recv_count       = recv_count_q;

	`SPI_TRB_ASSERT_ALWAYS(a_send_cnt_range, send_cnt_q <= CNT_W'(QUEUE_DEPTH), "send count overflow")
	`SPI_TRB_ASSERT_ALWAYS(a_recv_cnt_range, recv_cnt_q <= CNT_W'(QUEUE_DEPTH), "recv count overflow")
	`SPI_TRB_ASSERT_NOW(a_send_empty_ptrs, send_cnt_q == '0, send_head_q == send_tail_q, "send pointers disagree")
	`SPI_TRB_ASSERT_NOW(a_recv_empty_ptrs, recv_cnt_q == '0, recv_head_q == recv_tail_q, "recv pointers disagree")
	`SPI_TRB_ASSERT_NOW(a_load_nonempty, valid_s1 && load_s1, send_cnt_s1 != '0, "load from empty send queue")

endmodule
